// ----- sv/ips_pkg.sv -----
// shared types and constants for the interval profiler statistics unit
`default_nettype none
package ips_pkg;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_END    = 2'd1,
        CMD_RESET  = 2'd2,
        CMD_REPORT = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_FREQ   = 2'd1;

    // one scaled division per step of a report result
    typedef enum logic [2:0] {
        STEP_MIN  = 3'd0,
        STEP_MAX  = 3'd1,
        STEP_AVGT = 3'd2,
        STEP_AVG  = 3'd3,
        STEP_PCT  = 3'd4
    } t_step;

    localparam int          PROD_W      = 84;
    localparam logic [19:0] US_PER_SEC  = 20'd1000000;
    localparam logic [19:0] PCT_SCALE   = 20'd100;
    localparam logic [19:0] UNIT_SCALE  = 20'd1;
    localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [63:0] FREQ_RESET  = 64'd1000000;
    localparam logic [63:0] ALL_ONES64  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic  upd_begin;
        logic  upd_end;
        logic  upd_reset;
        logic  load_now;
        logic  op_start;
        logic  capture;
        t_step step;
    } t_dp_ctl;

    typedef struct packed {
        logic [4:0] active;
        logic       op_done;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- sv/ips_if.sv -----
// channel interfaces: configuration writes, input items and report results
`default_nettype none
interface ips_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface ips_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  counter_index;
    logic [63:0] timestamp;
    logic [4:0]  report_limit;
    modport source (output valid, command, counter_index, timestamp, report_limit,
                    input ready);
    modport sink   (input valid, command, counter_index, timestamp, report_limit,
                    output ready);
endinterface

interface ips_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  reported_index;
    logic [31:0] min_interval_us;
    logic [31:0] max_interval_us;
    logic [31:0] avg_interval_us;
    logic [6:0]  cpu_percent;
    logic        last;
    modport source (output valid, reported_index, min_interval_us, max_interval_us,
                    avg_interval_us, cpu_percent, last, input ready);
    modport sink   (input valid, reported_index, min_interval_us, max_interval_us,
                    avg_interval_us, cpu_percent, last, output ready);
endinterface
`default_nettype wire

// ----- sv/ips_mdiv.sv -----
// floor(a * b / c): split multiply (low then high partial product) then bit-serial restoring division
`default_nettype none
module ips_mdiv
    import ips_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_a,
    input  wire logic [19:0]       i_b,
    input  wire logic [63:0]       i_c,
    output logic                   o_done,
    output logic [PROD_W-1:0]      o_q
);
    localparam logic [6:0] LAST_BIT = 7'(PROD_W - 1);

    logic              r_busy;
    logic              r_mul_hi;
    logic              r_done;
    logic [6:0]        r_cnt;
    logic [31:0]       r_a_hi;
    logic [19:0]       r_b;
    logic [63:0]       r_c;
    logic [63:0]       r_rem;
    logic [PROD_W-1:0] r_acc;

    logic [64:0] rem_sh;
    logic        take;

    assign rem_sh = {r_rem, r_acc[PROD_W-1]};
    assign take   = rem_sh >= {1'b0, r_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_mul_hi <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_mul_hi <= 1'b1;
                r_a_hi   <= i_a[63:32];
                r_b      <= i_b;
                r_c      <= i_c;
                r_acc    <= PROD_W'(i_a[31:0] * i_b);
            end else if (r_mul_hi) begin
                r_mul_hi <= 1'b0;
                r_acc    <= r_acc + (PROD_W'(r_a_hi * r_b) << 32);
                r_rem    <= '0;
                r_cnt    <= '0;
            end else if (r_busy) begin
                r_rem <= take ? 64'(rem_sh - {1'b0, r_c}) : rem_sh[63:0];
                r_acc <= {r_acc[PROD_W-2:0], take};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // zero divisor gives zero
    assign o_done = r_done;
    assign o_q    = (r_c == 64'd0) ? '0 : r_acc;
endmodule
`default_nettype wire

// ----- sv/ips_dp.sv -----
// datapath: per-counter statistics, configuration registers and result registers
`default_nettype none
module ips_dp
    import ips_pkg::*;
#(
    parameter int NUM_COUNTERS = 16,
    parameter int IDX_W        = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_ctl          i_ctl,
    input  wire logic [IDX_W-1:0] i_rpt_idx,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [63:0]      i_cfg_data,
    input  wire logic [3:0]       i_counter_index,
    input  wire logic [63:0]      i_timestamp,
    output t_dp_sts               o_sts,
    output logic [31:0]           o_min_us,
    output logic [31:0]           o_max_us,
    output logic [31:0]           o_avg_us,
    output logic [6:0]            o_pct
);
    logic [63:0] r_start   [NUM_COUNTERS];
    logic [63:0] r_short   [NUM_COUNTERS];
    logic [63:0] r_long    [NUM_COUNTERS];
    logic [63:0] r_sum     [NUM_COUNTERS];
    logic [31:0] r_count   [NUM_COUNTERS];
    logic [63:0] r_mstart;
    logic [63:0] r_now;
    logic [4:0]  r_active;
    logic [63:0] r_freq;
    logic [63:0] r_avgt;
    logic [31:0] r_min_us, r_max_us, r_avg_us;
    logic [6:0]  r_pct;

    logic [IDX_W-1:0]  upd_idx;
    logic              idx_ok;
    logic [63:0]       dur;
    logic [4:0]        act_lim;
    logic [63:0]       op_a, op_c;
    logic [19:0]       op_b;
    logic              md_done;
    logic [PROD_W-1:0] md_q;
    logic [31:0]       q_sat;

    assign upd_idx = IDX_W'(i_counter_index);
    assign idx_ok  = {3'b0, i_counter_index} < 7'(NUM_COUNTERS);
    assign dur     = i_timestamp - r_start[upd_idx];
    assign act_lim = ({2'b0, r_active} > 7'(NUM_COUNTERS)) ? 5'(NUM_COUNTERS) : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_start[k] <= '0;
                r_short[k] <= ALL_ONES64;
                r_long[k]  <= '0;
                r_sum[k]   <= '0;
                r_count[k] <= '0;
            end
            r_mstart <= '0;
            r_active <= '0;
            r_freq   <= FREQ_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ACTIVE) begin
                    r_active <= i_cfg_data[4:0];
                end else if (i_cfg_index == REG_FREQ) begin
                    r_freq <= i_cfg_data;
                end
            end
            if (i_ctl.upd_begin && idx_ok) begin
                r_start[upd_idx] <= i_timestamp;
            end
            if (i_ctl.upd_end && idx_ok) begin
                if (dur < r_short[upd_idx]) begin
                    r_short[upd_idx] <= dur;
                end
                if (dur > r_long[upd_idx]) begin
                    r_long[upd_idx] <= dur;
                end
                r_sum[upd_idx]   <= r_sum[upd_idx] + dur;
                r_count[upd_idx] <= r_count[upd_idx] + 32'd1;
            end
            if (i_ctl.upd_reset) begin
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    if (k < int'(act_lim)) begin
                        r_start[k] <= '0;
                        r_short[k] <= ALL_ONES64;
                        r_long[k]  <= '0;
                        r_sum[k]   <= '0;
                        r_count[k] <= '0;
                    end
                end
                r_mstart <= i_timestamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_now) begin
            r_now <= i_timestamp;
        end
    end

    // operands of the current step, average ticks first then scaled
    always_comb begin
        op_a = r_sum[i_rpt_idx];
        op_b = PCT_SCALE;
        op_c = r_now - r_mstart;
        case (i_ctl.step)
            STEP_MIN: begin
                op_a = r_short[i_rpt_idx];
                op_b = US_PER_SEC;
                op_c = r_freq;
            end
            STEP_MAX: begin
                op_a = r_long[i_rpt_idx];
                op_b = US_PER_SEC;
                op_c = r_freq;
            end
            STEP_AVGT: begin
                op_a = r_sum[i_rpt_idx];
                op_b = UNIT_SCALE;
                op_c = {32'b0, r_count[i_rpt_idx]};
            end
            STEP_AVG: begin
                op_a = r_avgt;
                op_b = US_PER_SEC;
                op_c = r_freq;
            end
            default: begin
                op_a = r_sum[i_rpt_idx];
                op_b = PCT_SCALE;
                op_c = r_now - r_mstart;
            end
        endcase
    end

    ips_mdiv u_mdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.op_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_c     (op_c),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    assign q_sat = (|md_q[PROD_W-1:32]) ? SAT32 : md_q[31:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            case (i_ctl.step)
                STEP_MIN:  r_min_us <= q_sat;
                STEP_MAX:  r_max_us <= q_sat;
                STEP_AVGT: r_avgt   <= md_q[63:0];
                STEP_AVG:  r_avg_us <= q_sat;
                default:   r_pct    <= (md_q > PROD_W'(PCT_MAX)) ? PCT_MAX : md_q[6:0];
            endcase
        end
    end

    assign o_sts.active  = r_active;
    assign o_sts.op_done = md_done;
    assign o_min_us      = r_min_us;
    assign o_max_us      = r_max_us;
    assign o_avg_us      = r_avg_us;
    assign o_pct         = r_pct;
endmodule
`default_nettype wire

// ----- sv/ips_ctrl.sv -----
// controller: item acceptance and the report sequence over counters and steps
`default_nettype none
module ips_ctrl
    import ips_pkg::*;
#(
    parameter int NUM_COUNTERS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_command,
    input  wire logic [4:0] i_report_limit,
    input  wire t_dp_sts    i_sts,
    input  wire logic       i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic            o_last,
    output logic [4:0]      o_idx,
    output t_dp_ctl         o_ctl
);
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    t_step      r_step, n_step;
    logic [4:0] r_idx, n_idx;
    logic [4:0] r_n, n_n;

    logic       accept;
    t_cmd       cmd;
    logic [6:0] act_cap;
    logic [6:0] rpt_n;
    logic       is_last;

    assign cmd     = t_cmd'(i_command);
    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign act_cap = ({2'b0, i_sts.active} > 7'(NUM_COUNTERS)) ? 7'(NUM_COUNTERS)
                                                              : {2'b0, i_sts.active};
    assign rpt_n   = ({2'b0, i_report_limit} < act_cap) ? {2'b0, i_report_limit} : act_cap;
    assign is_last = (r_idx + 5'd1) == r_n;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_n     = r_n;
        case (r_state)
            ST_IDLE: begin
                if (accept && cmd == CMD_REPORT && rpt_n != 7'd0) begin
                    n_state = ST_START;
                    n_step  = STEP_MIN;
                    n_idx   = '0;
                    n_n     = rpt_n[4:0];
                end
            end
            ST_START: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.op_done) begin
                    case (r_step)
                        STEP_MIN:  n_step = STEP_MAX;
                        STEP_MAX:  n_step = STEP_AVGT;
                        STEP_AVGT: n_step = STEP_AVG;
                        STEP_AVG:  n_step = STEP_PCT;
                        default:   n_step = STEP_MIN;
                    endcase
                    n_state = (r_step == STEP_PCT) ? ST_EMIT : ST_START;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_START;
                        n_idx   = r_idx + 5'd1;
                        n_step  = STEP_MIN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_MIN;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
    end

    always_comb begin
        o_ctl.upd_begin = accept && cmd == CMD_BEGIN;
        o_ctl.upd_end   = accept && cmd == CMD_END;
        o_ctl.upd_reset = accept && cmd == CMD_RESET;
        o_ctl.load_now  = accept && cmd == CMD_REPORT;
        o_ctl.op_start  = r_state == ST_START;
        o_ctl.capture   = (r_state == ST_WAIT) && i_sts.op_done;
        o_ctl.step      = r_step;
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_state == ST_EMIT;
    assign o_last      = is_last;
    assign o_idx       = r_idx;
endmodule
`default_nettype wire

// ----- sv/interval_profiler_stats_unit.sv -----
// interval profiler: begin / end / reset items are accepted back to back
// a report runs five scaled divisions per counter, each a start with the low partial
// product, the high partial product, a bit-serial divide over the 84-bit product and a
// capture; each result is then held until it is taken, and the first division starts in
// the cycle after the report transaction is taken; no item is taken while a report runs
// synchronous active-low reset clears all statistics, active_counters to 0, frequency 1e6
`default_nettype none
module interval_profiler_stats_unit
    import ips_pkg::*;
#(
    parameter int NUM_COUNTERS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ips_cfg_if.sink    i_cfg,
    ips_item_if.sink   i_item,
    ips_res_if.source  o_res
);
    localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

    t_dp_ctl     ctl;
    t_dp_sts     sts;
    logic [4:0]  rpt_idx;
    logic        in_ready;
    logic        out_valid;
    logic        last;
    logic [31:0] min_us, max_us, avg_us;
    logic [6:0]  pct;

    assign i_cfg.ready = 1'b1;

    ips_ctrl #(.NUM_COUNTERS(NUM_COUNTERS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_item.valid),
        .i_command      (i_item.command),
        .i_report_limit (i_item.report_limit),
        .i_sts          (sts),
        .i_out_ready    (o_res.ready),
        .o_in_ready     (in_ready),
        .o_out_valid    (out_valid),
        .o_last         (last),
        .o_idx          (rpt_idx),
        .o_ctl          (ctl)
    );

    ips_dp #(.NUM_COUNTERS(NUM_COUNTERS), .IDX_W(IDX_W)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_rpt_idx       (IDX_W'(rpt_idx)),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_counter_index (i_item.counter_index),
        .i_timestamp     (i_item.timestamp),
        .o_sts           (sts),
        .o_min_us        (min_us),
        .o_max_us        (max_us),
        .o_avg_us        (avg_us),
        .o_pct           (pct)
    );

    assign i_item.ready          = in_ready;
    assign o_res.valid           = out_valid;
    assign o_res.reported_index  = rpt_idx[3:0];
    assign o_res.min_interval_us = min_us;
    assign o_res.max_interval_us = max_us;
    assign o_res.avg_interval_us = avg_us;
    assign o_res.cpu_percent     = pct;
    assign o_res.last            = last;
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for the interval profiler statistics unit
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ips_pkg::*;

    localparam int NCNT = 16;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  counter_index;
        logic [63:0] timestamp;
        logic [4:0]  report_limit;
    } t_item;

    typedef struct packed {
        logic [3:0]  reported_index;
        logic [31:0] min_us;
        logic [31:0] max_us;
        logic [31:0] avg_us;
        logic [6:0]  pct;
        logic        last;
    } t_stat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ips_cfg_if  cfg_bus ();
    ips_item_if item_bus ();
    ips_res_if  res_bus ();

    interval_profiler_stats_unit #(.NUM_COUNTERS(NCNT)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus.sink),
        .i_item  (item_bus.sink),
        .o_res   (res_bus.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [4:0]  m_active;
    logic [63:0] m_freq;
    logic [63:0] m_start [NCNT];
    logic [63:0] m_short [NCNT];
    logic [63:0] m_long  [NCNT];
    logic [63:0] m_sum   [NCNT];
    logic [31:0] m_cnt   [NCNT];
    logic [63:0] m_meas;

    t_item pending_items[$];
    t_stat expected_stats[$];
    int    n_fail = 0;
    int    n_mism = 0;
    bit    quiet = 1'b0;
    int    hold_off = 0;

    function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c, logic [63:0] cap);
        logic [127:0] q;
        if (c == 0) return 64'd0;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic int unsigned active_n();
        return (m_active > NCNT) ? NCNT : m_active;
    endfunction

    task automatic predict_item(t_item it);
        logic [63:0] d;
        logic [63:0] avgt;
        int unsigned n;
        t_stat s;
        case (it.command)
            CMD_BEGIN: m_start[it.counter_index] = it.timestamp;
            CMD_END: begin
                d = it.timestamp - m_start[it.counter_index];
                if (d < m_short[it.counter_index]) m_short[it.counter_index] = d;
                if (d > m_long[it.counter_index]) m_long[it.counter_index] = d;
                m_sum[it.counter_index] += d;
                m_cnt[it.counter_index] += 1;
            end
            CMD_RESET: begin
                for (int i = 0; i < active_n(); i++) begin
                    m_start[i] = 0; m_short[i] = ALL_ONES64; m_long[i] = 0;
                    m_sum[i] = 0; m_cnt[i] = 0;
                end
                m_meas = it.timestamp;
            end
            default: begin
                n = active_n();
                if (it.report_limit < n) n = it.report_limit;
                for (int i = 0; i < n; i++) begin
                    avgt = (m_cnt[i] != 0) ? m_sum[i] / {32'd0, m_cnt[i]} : 64'd0;
                    s.reported_index = i[3:0];
                    s.min_us = scale_div(m_short[i], 64'd1000000, m_freq, SAT32);
                    s.max_us = scale_div(m_long[i], 64'd1000000, m_freq, SAT32);
                    s.avg_us = (m_cnt[i] != 0) ?
                        scale_div(avgt, 64'd1000000, m_freq, SAT32) : 32'd0;
                    s.pct = scale_div(m_sum[i], 64'd100, it.timestamp - m_meas, 64'd100);
                    s.last = (i + 1 == n);
                    expected_stats.push_back(s);
                end
            end
        endcase
    endtask

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else if (!item_bus.valid || item_bus.ready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                item_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         (quiet || $urandom_range(0, 9) != 0)) begin
                t_item it;
                it = pending_items.pop_front();
                predict_item(it);
                item_bus.valid         <= 1'b1;
                item_bus.command       <= it.command;
                item_bus.counter_index <= it.counter_index;
                item_bus.timestamp     <= it.timestamp;
                item_bus.report_limit  <= it.report_limit;
            end else begin
                item_bus.valid <= 1'b0;
                // idle burst of random length, drawn into in_gap
                if (!quiet && pending_items.size() > 0) in_gap <= $urandom_range(0, 13);
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                t_stat got, exp_s;
                got = {res_bus.reported_index, res_bus.min_interval_us,
                       res_bus.max_interval_us, res_bus.avg_interval_us,
                       res_bus.cpu_percent, res_bus.last};
                if (expected_stats.size() == 0) begin
                    n_fail++;
                    if (n_mism++ < 10) $display("unexpected result %h", got);
                end else begin
                    exp_s = expected_stats.pop_front();
                    if (got !== exp_s) begin
                        n_fail++;
                        if (n_mism++ < 10) begin
                            $display("mismatch idx exp %0d/%0d min %0d/%0d max %0d/%0d",
                                     exp_s.reported_index, got.reported_index,
                                     exp_s.min_us, got.min_us, exp_s.max_us, got.max_us);
                            $display("  avg %0d/%0d pct %0d/%0d last %0b/%0b",
                                     exp_s.avg_us, got.avg_us, exp_s.pct, got.pct,
                                     exp_s.last, got.last);
                        end
                    end
                end
            end
            if (hold_off > 0) begin
                res_bus.ready <= 1'b0;
            end else if (quiet) begin
                res_bus.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res_bus.ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 13);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_ACTIVE) m_active = val[4:0];
        else if (idx == REG_FREQ) m_freq = val;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || expected_stats.size() > 0 || item_bus.valid)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic t_item mk(t_cmd c, int idx, logic [63:0] ts, int lim);
        t_item it;
        it.command = c; it.counter_index = idx[3:0];
        it.timestamp = ts; it.report_limit = lim[4:0];
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    logic [63:0] clock_now = 0;

    // a random item, mostly begin/end items on indices below the small active size
    task automatic push_random(int nact);
        int k;
        int idx;
        k = $urandom_range(0, 99);
        idx = $urandom_range(0, 15);
        if (nact > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, nact - 1);
        clock_now += $urandom_range(0, 4000);
        if ($urandom_range(0, 30) == 0) clock_now = rnd64();
        if (k < 40) pending_items.push_back(mk(CMD_BEGIN, idx, clock_now, 0));
        else if (k < 80) pending_items.push_back(mk(CMD_END, idx, clock_now, 0));
        else if (k < 85) pending_items.push_back(mk(CMD_RESET, idx, clock_now, 0));
        else pending_items.push_back(mk(CMD_REPORT, idx, clock_now, $urandom_range(0, 4)));
    endtask

    initial begin
        int nact;
        cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
        item_bus.valid = 1'b0; item_bus.command = '0; item_bus.counter_index = '0;
        item_bus.timestamp = '0; item_bus.report_limit = '0;
        res_bus.ready = 1'b0;
        m_active = 0; m_freq = FREQ_RESET; m_meas = 0;
        for (int i = 0; i < NCNT; i++) begin
            m_start[i] = 0; m_short[i] = ALL_ONES64; m_long[i] = 0; m_sum[i] = 0; m_cnt[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: report before any config, all-ones min, extremes
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd5, 16));
        wait_idle();
        cfg_write(REG_ACTIVE, 64'd3);
        cfg_write(2'd2, 64'd7);
        pending_items.push_back(mk(CMD_REPORT, 15, 64'd0, 16));
        pending_items.push_back(mk(CMD_RESET, 0, 64'd100, 0));
        pending_items.push_back(mk(CMD_BEGIN, 0, 64'd200, 0));
        pending_items.push_back(mk(CMD_END, 0, 64'd1200, 0));
        pending_items.push_back(mk(CMD_BEGIN, 1, ALL_ONES64, 0));
        pending_items.push_back(mk(CMD_END, 1, 64'd10, 0));
        pending_items.push_back(mk(CMD_BEGIN, 15, 64'd3, 0));
        pending_items.push_back(mk(CMD_END, 15, 64'd9, 0));
        pending_items.push_back(mk(CMD_REPORT, 7, 64'd100, 3));
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd5000, 31));
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd5000, 2));
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd5000, 0));
        wait_idle();
        cfg_write(REG_FREQ, ALL_ONES64);
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd7000, 3));
        wait_idle();
        cfg_write(REG_FREQ, 64'd1);
        cfg_write(REG_ACTIVE, 64'd31);
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd7000, 16));
        pending_items.push_back(mk(CMD_RESET, 0, ALL_ONES64, 0));
        pending_items.push_back(mk(CMD_REPORT, 0, 64'd0, 1));
        wait_idle();

        // random phases with varying configuration
        for (int ph = 0; ph < 6; ph++) begin
            nact = (ph == 5) ? 16 : $urandom_range(1, 4);
            if (ph == 0) nact = 0;
            cfg_write(REG_ACTIVE, 64'(nact));
            case (ph)
                0: cfg_write(REG_FREQ, 64'd1000000);
                1: cfg_write(REG_FREQ, 64'd1);
                2: cfg_write(REG_FREQ, rnd64());
                3: cfg_write(REG_FREQ, 64'($urandom_range(1, 100000)));
                4: cfg_write(REG_FREQ, 64'd100000000);
                default: cfg_write(REG_FREQ, 64'd1000);
            endcase
            pending_items.push_back(mk(CMD_RESET, 0, clock_now, 0));
            for (int j = 0; j < 75; j++) push_random(nact > 4 ? 4 : nact);
            if (ph == 3) begin
                pending_items.push_back(mk(CMD_REPORT, 0, clock_now + 50, 4));
                pending_items.push_back(mk(CMD_REPORT, 0, clock_now + 90, 4));
                hold_off = 3000;
            end
            if (ph == 5) begin
                quiet = 1'b1;
                pending_items.push_back(mk(CMD_REPORT, 0, clock_now + 10, 16));
            end
            wait_idle();
        end

        if (n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
